FILE: rtl/adam_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Adam update engine package
// Field types, fixed-point constants and serial unit step counts.
// ----------------------------------------------------------------------------
package adam_pkg;

	typedef logic [11:0]        index_t;
	typedef logic signed [31:0] q4_28_t;
	typedef logic [23:0]        rate_t;

	localparam int ENTRY_COUNT_DEF = 4096;

	// Beta constants and their complements in unsigned Q0.32.
	localparam logic [31:0] B1_Q32 = 32'd3865470566;
	localparam logic [31:0] C1_Q32 = 32'd429496730;
	localparam logic [31:0] B2_Q32 = 32'd4290672329;
	localparam logic [31:0] C2_Q32 = 32'd4294967;
	localparam logic [32:0] EPS_Q28 = 33'd3;
	localparam rate_t       LR_RESET = 24'd16777;

	// Counter width and step counts of the bit-serial units.
	localparam int CNT_W      = 7;
	localparam int MUL_STEPS  = 32;
	localparam int DIV_STEPS  = 80;
	localparam int SQRT_STEPS = 32;

endpackage
`default_nettype wire

FILE: rtl/adam_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Adam update engine channels
// Valid/ready interfaces for the entry words and the result words.
// ----------------------------------------------------------------------------
interface adam_item_if;
	logic              valid;
	logic              ready;
	adam_pkg::index_t  entry_index;
	adam_pkg::q4_28_t  gradient;
	adam_pkg::q4_28_t  current_value;
	logic              end_of_step;

	modport source (output valid, output entry_index, output gradient,
		output current_value, output end_of_step, input ready);
	modport sink (input valid, input entry_index, input gradient,
		input current_value, input end_of_step, output ready);
endinterface

interface adam_result_if;
	logic              valid;
	logic              ready;
	adam_pkg::q4_28_t  updated_value;
	logic              saturated;

	modport source (output valid, output updated_value, output saturated,
		input ready);
	modport sink (input valid, input updated_value, input saturated,
		output ready);
endinterface
`default_nettype wire

FILE: rtl/adam_optimizer_update_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Adam optimizer update engine
// Updates per-entry moments and returns the parameter value updated by the bias-corrected step.
// ----------------------------------------------------------------------------
// Channel      Dir  Handshake     Content
// item         in   valid/ready   entry_index, gradient, current_value, end_of_step
// result       out  valid/ready   updated_value, saturated
// cfg          in   write enable  step size (Q0.24)
//
// The sequencer takes a new word only once it is done with the last one; the
// three serial divisions, four serial multiplies and the square root share it,
// and closing a step adds two more serial multiplies for the beta powers.
// After reset the moment memory is cleared, one entry a cycle.
// A waiting result word sits in the output register; the sequencer stalls only
// when a second result is ready before the first was taken.
// ----------------------------------------------------------------------------
module adam_optimizer_update_top #(
	parameter int ENTRY_COUNT = adam_pkg::ENTRY_COUNT_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	adam_item_if.sink          item,
	adam_result_if.source      result,
	input  wire logic          cfg_wr_en,
	input  wire adam_pkg::rate_t cfg_wr_data
);

	localparam int AW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

	localparam logic [4:0] S_CLEAR   = 5'd0;
	localparam logic [4:0] S_IDLE    = 5'd1;
	localparam logic [4:0] S_READ    = 5'd2;
	localparam logic [4:0] S_LOAD    = 5'd3;
	localparam logic [4:0] S_MUL_SQ  = 5'd4;
	localparam logic [4:0] S_PREP_M  = 5'd5;
	localparam logic [4:0] S_MUL_M   = 5'd6;
	localparam logic [4:0] S_PREP_V  = 5'd7;
	localparam logic [4:0] S_MUL_V   = 5'd8;
	localparam logic [4:0] S_WRITE   = 5'd9;
	localparam logic [4:0] S_DIV_M   = 5'd10;
	localparam logic [4:0] S_PREP_VH = 5'd11;
	localparam logic [4:0] S_DIV_V   = 5'd12;
	localparam logic [4:0] S_PREP_SQ = 5'd13;
	localparam logic [4:0] S_SQRT    = 5'd14;
	localparam logic [4:0] S_PREP_LR = 5'd15;
	localparam logic [4:0] S_MUL_LR  = 5'd16;
	localparam logic [4:0] S_PREP_D  = 5'd17;
	localparam logic [4:0] S_DIV_D   = 5'd18;
	localparam logic [4:0] S_RESULT  = 5'd19;
	localparam logic [4:0] S_MUL_P1  = 5'd20;
	localparam logic [4:0] S_PREP_P2 = 5'd21;
	localparam logic [4:0] S_MUL_P2  = 5'd22;
	localparam logic [4:0] S_POW_END = 5'd23;

	localparam logic [adam_pkg::CNT_W-1:0] MUL_LAST  = adam_pkg::CNT_W'(adam_pkg::MUL_STEPS - 1);
	localparam logic [adam_pkg::CNT_W-1:0] DIV_LAST  = adam_pkg::CNT_W'(adam_pkg::DIV_STEPS - 1);
	localparam logic [adam_pkg::CNT_W-1:0] SQRT_LAST = adam_pkg::CNT_W'(adam_pkg::SQRT_STEPS - 1);

	// Control state
	logic [4:0]                   state_q;
	logic [adam_pkg::CNT_W-1:0]   cnt_q;
	logic [AW-1:0]                clr_q;
	logic                         out_valid_q;
	logic [31:0]                  beta1_q;
	logic [31:0]                  beta2_q;
	adam_pkg::rate_t              lr_q;

	// Item and datapath registers
	logic [AW-1:0]  idx_q;
	logic [31:0]    g_q;
	logic [31:0]    val_q;
	logic           eos_q;
	logic [31:0]    m_q;
	logic [47:0]    v_q;
	logic [47:0]    g2_q;
	logic           sign_q;
	logic [31:0]    mnew_q;
	logic [47:0]    vnew_q;
	logic [31:0]    mhat_q;
	logic [32:0]    den_q;
	logic           sat_q;
	logic [31:0]    upd_q;
	logic           sat_out_q;

	logic [79:0]    mul_acc_q;
	logic [47:0]    mul_a_q;
	logic [31:0]    mul_b_q;
	logic [79:0]    div_num_q;
	logic [32:0]    div_rem_q;
	logic [32:0]    div_den_q;
	logic [63:0]    sq_op_q;
	logic [33:0]    sq_rem_q;
	logic [31:0]    sq_root_q;

	logic [79:0]    moment_mem_q [ENTRY_COUNT];
	logic [79:0]    rd_data_q;

	// Combinational helpers
	logic [31:0]    idx_red;
	logic [31:0]    g_mag;
	logic [32:0]    dm;
	logic [32:0]    dm_mag;
	logic [48:0]    dv;
	logic [47:0]    dv_mag;
	logic [79:0]    rnd;
	logic [31:0]    r1;
	logic [47:0]    r2;
	logic [31:0]    mnew;
	logic [47:0]    vnew;
	logic [31:0]    mmag;
	logic [79:0]    mul_next;
	logic [33:0]    div_trial;
	logic [33:0]    div_diff;
	logic           div_ge;
	logic [35:0]    sq_trial_rem;
	logic [35:0]    sq_trial;
	logic [35:0]    sq_diff;
	logic           sq_ge;
	logic [65:0]    res_wide;
	logic           res_hi;
	logic           res_lo;
	logic           out_load;
	logic           mem_we;
	logic [AW-1:0]  mem_waddr;
	logic [79:0]    mem_wdata;

	// Entry index modulo ENTRY_COUNT by restoring subtraction.
	always_comb begin
		idx_red = 32'(item.entry_index);
		for (int k = 7; k >= 0; k--) begin
			if (idx_red >= (32'(ENTRY_COUNT) << k)) begin
				idx_red = idx_red - (32'(ENTRY_COUNT) << k);
			end
		end
	end

	always_comb begin
		g_mag  = g_q[31] ? (~g_q + 32'd1) : g_q;
		dm     = {g_q[31], g_q} - {m_q[31], m_q};
		dm_mag = dm[32] ? (~dm + 33'd1) : dm;
		dv     = {1'b0, g2_q} - {1'b0, v_q};
		dv_mag = dv[48] ? (~dv[47:0] + 48'd1) : dv[47:0];
		// Round to nearest, halves away from zero, on the magnitude.
		rnd    = mul_acc_q + 80'h8000_0000;
		r1     = rnd[63:32];
		r2     = rnd[79:32];
		mnew   = sign_q ? (m_q - r1) : (m_q + r1);
		vnew   = sign_q ? (v_q - r2) : (v_q + r2);
		mmag   = mnew_q[31] ? (~mnew_q + 32'd1) : mnew_q;
	end

	always_comb begin
		mul_next     = {mul_acc_q[78:0], 1'b0} + (mul_b_q[31] ? {32'd0, mul_a_q} : 80'd0);
		div_trial    = {div_rem_q, div_num_q[79]};
		div_ge       = div_trial >= {1'b0, div_den_q};
		div_diff     = div_trial - {1'b0, div_den_q};
		sq_trial_rem = {sq_rem_q, sq_op_q[63:62]};
		sq_trial     = {2'b00, sq_root_q, 2'b01};
		sq_ge        = sq_trial_rem >= sq_trial;
		sq_diff      = sq_trial_rem - sq_trial;
	end

	always_comb begin
		res_wide = mnew_q[31]
			? ({{34{val_q[31]}}, val_q} + {2'b00, div_num_q[63:0]})
			: ({{34{val_q[31]}}, val_q} - {2'b00, div_num_q[63:0]});
		res_hi   = !res_wide[65] && (res_wide[65:31] != 35'd0);
		res_lo   = res_wide[65] && (res_wide[65:31] != {35{1'b1}});
		out_load = (state_q == S_RESULT) && (!out_valid_q || result.ready);
	end

	assign item.ready           = (state_q == S_IDLE);
	assign result.valid         = out_valid_q;
	assign result.updated_value = upd_q;
	assign result.saturated     = sat_out_q;

	// Moment memory: {first moment, second moment} per entry.
	always_comb begin
		mem_we    = (state_q == S_CLEAR) || (state_q == S_WRITE);
		mem_waddr = (state_q == S_CLEAR) ? clr_q : idx_q;
		mem_wdata = (state_q == S_CLEAR) ? 80'd0 : {mnew_q, vnew};
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			moment_mem_q[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= moment_mem_q[idx_q];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			cnt_q       <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			beta1_q     <= adam_pkg::B1_Q32;
			beta2_q     <= adam_pkg::B2_Q32;
			lr_q        <= adam_pkg::LR_RESET;
		end else begin
			if (cfg_wr_en) begin
				lr_q <= cfg_wr_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q) inside
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(ENTRY_COUNT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (item.valid) begin
						state_q <= S_READ;
					end
				end
				S_READ:    state_q <= S_LOAD;
				S_LOAD: begin
					cnt_q   <= '0;
					state_q <= S_MUL_SQ;
				end
				S_MUL_SQ, S_MUL_M, S_MUL_V, S_MUL_LR, S_MUL_P1, S_MUL_P2: begin
					if (cnt_q == MUL_LAST) begin
						cnt_q <= '0;
						case (state_q)
							S_MUL_SQ: state_q <= S_PREP_M;
							S_MUL_M:  state_q <= S_PREP_V;
							S_MUL_V:  state_q <= S_WRITE;
							S_MUL_LR: state_q <= S_PREP_D;
							S_MUL_P1: state_q <= S_PREP_P2;
							default:  state_q <= S_POW_END;
						endcase
					end else begin
						cnt_q <= cnt_q + adam_pkg::CNT_W'(1);
					end
				end
				S_DIV_M, S_DIV_V, S_DIV_D: begin
					if (cnt_q == DIV_LAST) begin
						cnt_q <= '0;
						case (state_q)
							S_DIV_M: state_q <= S_PREP_VH;
							S_DIV_V: state_q <= S_PREP_SQ;
							default: state_q <= S_RESULT;
						endcase
					end else begin
						cnt_q <= cnt_q + adam_pkg::CNT_W'(1);
					end
				end
				S_SQRT: begin
					if (cnt_q == SQRT_LAST) begin
						cnt_q   <= '0;
						state_q <= S_PREP_LR;
					end else begin
						cnt_q <= cnt_q + adam_pkg::CNT_W'(1);
					end
				end
				S_PREP_M:  state_q <= S_MUL_M;
				S_PREP_V:  state_q <= S_MUL_V;
				S_WRITE:   state_q <= S_DIV_M;
				S_PREP_VH: state_q <= S_DIV_V;
				S_PREP_SQ: state_q <= S_SQRT;
				S_PREP_LR: state_q <= S_MUL_LR;
				S_PREP_D:  state_q <= S_DIV_D;
				S_RESULT: begin
					if (out_load) begin
						state_q <= eos_q ? S_MUL_P1 : S_IDLE;
					end
				end
				S_PREP_P2: begin
					beta1_q <= mul_acc_q[63:32];
					state_q <= S_MUL_P2;
				end
				S_POW_END: begin
					beta2_q <= mul_acc_q[63:32];
					state_q <= S_IDLE;
				end
				default:   state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (state_q) inside
			S_IDLE: begin
				idx_q <= idx_red[AW-1:0];
				g_q   <= item.gradient;
				val_q <= item.current_value;
				eos_q <= item.end_of_step;
				sat_q <= 1'b0;
			end
			S_LOAD: begin
				m_q       <= rd_data_q[79:48];
				v_q       <= rd_data_q[47:0];
				mul_acc_q <= '0;
				mul_a_q   <= {16'd0, g_mag};
				mul_b_q   <= g_mag;
			end
			S_MUL_SQ, S_MUL_M, S_MUL_V, S_MUL_LR, S_MUL_P1, S_MUL_P2: begin
				mul_acc_q <= mul_next;
				mul_b_q   <= {mul_b_q[30:0], 1'b0};
			end
			S_PREP_M: begin
				g2_q      <= mul_acc_q[63:16];
				sign_q    <= dm[32];
				mul_acc_q <= '0;
				mul_a_q   <= {15'd0, dm_mag};
				mul_b_q   <= adam_pkg::C1_Q32;
			end
			S_PREP_V: begin
				mnew_q    <= mnew;
				sign_q    <= dv[48];
				mul_acc_q <= '0;
				mul_a_q   <= dv_mag;
				mul_b_q   <= adam_pkg::C2_Q32;
			end
			S_WRITE: begin
				vnew_q    <= vnew;
				div_num_q <= {16'd0, mmag, 32'd0};
				div_rem_q <= '0;
				div_den_q <= 33'h1_0000_0000 - {1'b0, beta1_q};
			end
			S_DIV_M, S_DIV_V, S_DIV_D: begin
				div_num_q <= {div_num_q[78:0], div_ge};
				div_rem_q <= div_ge ? div_diff[32:0] : div_trial[32:0];
			end
			S_PREP_VH: begin
				if (div_num_q > 80'h8000_0000) begin
					mhat_q <= 32'h8000_0000;
					sat_q  <= 1'b1;
				end else begin
					mhat_q <= div_num_q[31:0];
				end
				div_num_q <= {vnew_q, 32'd0};
				div_rem_q <= '0;
				div_den_q <= 33'h1_0000_0000 - {1'b0, beta2_q};
			end
			S_PREP_SQ: begin
				if (div_num_q[79:48] != 32'd0) begin
					sq_op_q <= {48'hFFFF_FFFF_FFFF, 16'd0};
					sat_q   <= 1'b1;
				end else begin
					sq_op_q <= {div_num_q[47:0], 16'd0};
				end
				sq_rem_q  <= '0;
				sq_root_q <= '0;
			end
			S_SQRT: begin
				sq_op_q   <= {sq_op_q[61:0], 2'b00};
				sq_rem_q  <= sq_ge ? sq_diff[33:0] : sq_trial_rem[33:0];
				sq_root_q <= {sq_root_q[30:0], sq_ge};
			end
			S_PREP_LR: begin
				den_q     <= {1'b0, sq_root_q} + adam_pkg::EPS_Q28;
				mul_acc_q <= '0;
				mul_a_q   <= {24'd0, lr_q};
				mul_b_q   <= mhat_q;
			end
			S_PREP_D: begin
				div_num_q <= {mul_acc_q[75:0], 4'd0};
				div_rem_q <= '0;
				div_den_q <= den_q;
			end
			S_RESULT: begin
				if (out_load) begin
					upd_q     <= res_hi ? 32'h7FFF_FFFF
						: (res_lo ? 32'h8000_0000 : res_wide[31:0]);
					sat_out_q <= sat_q || res_hi || res_lo;
					mul_acc_q <= '0;
					mul_a_q   <= {16'd0, beta1_q};
					mul_b_q   <= adam_pkg::B1_Q32;
				end
			end
			S_PREP_P2: begin
				mul_acc_q <= '0;
				mul_a_q   <= {16'd0, beta2_q};
				mul_b_q   <= adam_pkg::B2_Q32;
			end
			default: begin
			end
		endcase
	end

	// Checks
	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> state_q == S_READ)
		else $error("accepted word did not start a memory read");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_RESULT)
		else $error("result word raised outside the result state");

	a_mhat_clip: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV_V |-> mhat_q <= 32'h8000_0000)
		else $error("bias-corrected first moment exceeds its clip value");

	a_mul_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL_SQ || state_q == S_MUL_M || state_q == S_MUL_V ||
		 state_q == S_MUL_LR || state_q == S_MUL_P1 || state_q == S_MUL_P2)
		|-> cnt_q <= MUL_LAST)
		else $error("serial multiplier ran past its last bit");

	a_no_clobber: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result.ready && state_q == S_RESULT |=> state_q == S_RESULT)
		else $error("result overwritten while still waiting");

endmodule
`default_nettype wire

FILE: verif/tb_adam_optimizer_update_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Adam update engine testbench
// Feeds directed and random entry words and checks every result word against
// a fixed-point model of the moment update, bias correction and step size.
// ----------------------------------------------------------------------------
module tb_adam_optimizer_update_top;

	localparam int ENTRIES = 4096;
	localparam int LATENCY = 600;
	localparam longint CYCLE_LIMIT = 10000000;

	typedef struct {
		adam_pkg::index_t idx;
		adam_pkg::q4_28_t grad;
		adam_pkg::q4_28_t val;
		logic   eos;
		logic   known;  // expected result typed into the table
		adam_pkg::q4_28_t exp_val;
		logic   exp_sat;
	} entry_row_t;

	typedef struct {
		adam_pkg::q4_28_t val;
		logic   sat;
	} param_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	adam_pkg::rate_t cfg_wr_data = '0;

	adam_item_if item_ch ();
	adam_result_if res_ch ();

	adam_optimizer_update_top dut (
		.clk(clk), .arst_n(arst_n), .item(item_ch.sink), .result(res_ch.source),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state.
	logic signed [31:0] m_store [ENTRIES];
	logic [47:0] v_store [ENTRIES];
	logic [31:0] pow1, pow2;
	adam_pkg::rate_t lr;

	param_word_t pending_words [$];
	int errors = 0;
	int row_errors = 0;
	longint cycles = 0;

	function automatic longint round_frac(longint x, logic [31:0] c);
		logic [63:0] mag, hi, lo, r;
		mag = x < 0 ? -x : x;
		hi = mag >> 32;
		lo = mag & 64'hFFFF_FFFF;
		r = hi * c + ((lo * c + 64'h8000_0000) >> 32);
		return x < 0 ? -longint'(r) : longint'(r);
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] n);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic param_word_t adam_update(entry_row_t e);
		param_word_t w;
		longint g, m, v, g2, res;
		logic [63:0] d1, d2, mmag, mhat, vhat, qhi, rem, den, delta;
		logic [127:0] prod;
		int i;
		i = e.idx % ENTRIES;
		g = e.grad;
		w.sat = 1'b0;
		m = m_store[i];
		v = v_store[i];
		g2 = longint'(64'(g * g) >> 16);
		m = m + round_frac(g - m, adam_pkg::C1_Q32);
		v = (v + round_frac(g2 - v, adam_pkg::C2_Q32)) & 64'hFFFF_FFFF_FFFF;
		m_store[i] = m[31:0];
		v_store[i] = v[47:0];
		d1 = 64'h1_0000_0000 - pow1;
		d2 = 64'h1_0000_0000 - pow2;
		mmag = m < 0 ? -m : m;
		mhat = (mmag << 32) / d1;
		if (mhat > 64'h8000_0000) begin
			mhat = 64'h8000_0000;
			w.sat = 1'b1;
		end
		qhi = v / d2;
		if (qhi >= 64'h1_0000) begin
			vhat = 64'hFFFF_FFFF_FFFF;
			w.sat = 1'b1;
		end else begin
			rem = v % d2;
			vhat = (qhi << 32) + ((rem << 32) / d2);
		end
		den = int_sqrt(vhat << 16) + adam_pkg::EPS_Q28;
		prod = 128'(lr) * mhat * 16;
		delta = 64'(prod / den);
		res = m < 0 ? longint'(e.val) + longint'(delta) : longint'(e.val) - longint'(delta);
		if (res > 64'sd2147483647) begin
			res = 2147483647;
			w.sat = 1'b1;
		end else if (res < -64'sd2147483648) begin
			res = -2147483648;
			w.sat = 1'b1;
		end
		if (e.eos) begin
			pow1 = 32'((64'(pow1) * adam_pkg::B1_Q32) >> 32);
			pow2 = 32'((64'(pow2) * adam_pkg::B2_Q32) >> 32);
		end
		w.val = res[31:0];
		return w;
	endfunction

	// Receiver: stalls on a repeating pattern, with random extra readiness on top and one window of steady readiness.
	logic [15:0] stall_pattern = 16'b1100_0000_1011_0000;
	int stall_pos = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		stall_pos <= stall_pos + 1;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= (stall_pos >= 4096 && stall_pos < 6000) ? 1'b1 :
				!stall_pattern[stall_pos[3:0]] || ($urandom_range(0, 3) == 0);
			if (res_ch.valid && res_ch.ready) begin
				if (pending_words.size() == 0) begin
					$display("%0t: result word with none expected: %h sat %b", $time,
						res_ch.updated_value, res_ch.saturated);
					errors++;
				end else begin
					param_word_t w;
					w = pending_words.pop_front();
					if (res_ch.updated_value !== w.val || res_ch.saturated !== w.sat) begin
						$display("%0t: mismatch expected %h sat %b, actual %h sat %b", $time,
							w.val, w.sat, res_ch.updated_value, res_ch.saturated);
						errors++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	int burst_left = 0;

	// The valid line stays high after an acceptance so that the next word can
	// follow at once; it drops only before a gap or a wait.
	task automatic send_word(entry_row_t e);
		param_word_t w;
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 500) : 0;
			if (gap != 0) begin
				item_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		item_ch.valid <= 1'b1;
		item_ch.entry_index <= e.idx;
		item_ch.gradient <= e.grad;
		item_ch.current_value <= e.val;
		item_ch.end_of_step <= e.eos;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		w = adam_update(e);
		if (e.known && (w.val !== e.exp_val || w.sat !== e.exp_sat)) begin
			$display("%0t: table row disagrees, expected %h sat %b, predicted %h sat %b",
				$time, e.exp_val, e.exp_sat, w.val, w.sat);
			row_errors++;
		end
		pending_words.insert(pending_words.size(), w);
	endtask

	task automatic wait_empty();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_words.size() != 0) @(posedge clk);
	endtask

	task automatic drain();
		wait_empty();
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic set_rate(adam_pkg::rate_t r);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= r;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		lr = r;
	endtask

	function automatic entry_row_t row(adam_pkg::index_t i, adam_pkg::q4_28_t g,
		adam_pkg::q4_28_t v, logic eos,
		logic known = 0, adam_pkg::q4_28_t ev = 0, logic es = 0);
		entry_row_t e;
		e.idx = i; e.grad = g; e.val = v; e.eos = eos;
		e.known = known; e.exp_val = ev; e.exp_sat = es;
		return e;
	endfunction

	entry_row_t directed [$];
	adam_pkg::rate_t rates [5] = '{24'hFFFFFF, 24'd0, 24'd167772, 24'd16777, 24'd1};

	task automatic add_row(entry_row_t r);
		directed.insert(directed.size(), r);
	endtask

	initial begin
		entry_row_t e;
		int hot;
		item_ch.valid = 1'b0;
		item_ch.entry_index = '0;
		item_ch.gradient = '0;
		item_ch.current_value = '0;
		item_ch.end_of_step = 1'b0;
		for (int i = 0; i < ENTRIES; i++) begin
			m_store[i] = 0;
			v_store[i] = 0;
		end
		pow1 = adam_pkg::B1_Q32;
		pow2 = adam_pkg::B2_Q32;
		lr = adam_pkg::LR_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Zero gradient after reset leaves the value unchanged.
		add_row(row(12'd0, 0, 32'sh7FFF_FFFF, 0, 1, 32'sh7FFF_FFFF, 0));
		add_row(row(12'd4095, 0, 32'sh8000_0000, 0, 1, 32'sh8000_0000, 0));
		add_row(row(12'd1, 32'sh7FFF_FFFF, 32'sh8000_0000, 0));
		add_row(row(12'd2, 32'sh8000_0000, 32'sh7FFF_FFFF, 0));
		add_row(row(12'd3, 1, 0, 0));
		add_row(row(12'd4, -1, 0, 1));
		add_row(row(12'd1, 32'sh7FFF_FFFF, 32'sh7FFF_FFF0, 0));
		add_row(row(12'd2, 32'sh8000_0000, 32'sh8000_0010, 1));
		add_row(row(12'd5, 32'sh1000_0000, 32'sh1000_0000, 0));
		add_row(row(12'd5, -32'sh1000_0000, 32'sh5555_5555, 1));
		add_row(row(12'hAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 0));
		add_row(row(12'h555, 32'shAAAA_AAAA, 32'sh5555_5555, 0));
		foreach (directed[k]) send_word(directed[k]);
		drain();

		// Random phases through several rates; early-step powers give big corrections.
		foreach (rates[p]) begin
			set_rate(rates[p]);
			hot = $urandom_range(0, 4095);
			for (int n = 0; n < 240; n++) begin
				case ($urandom_range(0, 3))
					0: e = row(adam_pkg::index_t'($urandom_range(0, 4095)), $urandom,
						$urandom, 0);
					1: e = row(adam_pkg::index_t'(hot + int'($urandom_range(0, 7))),
						$urandom, $urandom, 0);
					2: e = row(adam_pkg::index_t'($urandom_range(0, 15)),
						$signed($urandom) >>> $urandom_range(0, 30), $urandom, 0);
					default: e = row(adam_pkg::index_t'($urandom_range(0, 4095)),
						$urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000,
						$urandom_range(0, 1) ? 32'sh7FFF_FF00 : 32'sh8000_00FF, 0);
				endcase
				e.eos = ($urandom_range(0, 19) == 0);
				send_word(e);
				if (n == 120) wait_empty();
			end
			drain();
		end

		if (errors == 0 && row_errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
